FILE: src/deq_pkg.sv
// ============================================================================
// deq_pkg: shared types for the double-ended queue
// Operation codes, status codes, cell control and channel payload structs.
// ============================================================================
package deq_pkg;

  // Requested operation, as carried in the func field
  typedef enum logic [1:0] {
    FUNC_PUSH_FRONT = 2'd0,
    FUNC_PUSH_BACK  = 2'd1,
    FUNC_POP_FRONT  = 2'd2,
    FUNC_POP_BACK   = 2'd3
  } deq_func_t;

  // Result status
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY_POP = 2'd1,
    STAT_FULL_PUSH = 2'd2
  } deq_status_t;

  // Per-cycle action of every cell in a chain
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_SHIFT_IN   = 2'd1,  // take left neighbor, head takes new data
    CELL_SHIFT_OUT  = 2'd2,  // take right neighbor, head is dropped
    CELL_TAIL_WRITE = 2'd3   // cell at the fill position takes new data
  } deq_cell_op_t;

  // Control broadcast from the top level to a chain
  typedef struct packed {
    deq_cell_op_t op;
    logic [12:0]  tail_pos;  // fill count before the operation
  } deq_cell_ctrl_t;

  localparam int unsigned FIELD_WIDTH = 32;
  localparam int unsigned COUNT_WIDTH = 5;
  localparam int unsigned POS_WIDTH   = 13;

  typedef struct packed {
    logic [1:0]                     func;
    logic signed [FIELD_WIDTH-1:0]  data_in;
  } deq_in_t;

  typedef struct packed {
    logic signed [FIELD_WIDTH-1:0]  front_value;
    logic signed [FIELD_WIDTH-1:0]  back_value;
    logic [COUNT_WIDTH-1:0]         entry_count;
    logic                           is_empty;
    logic [1:0]                     status;
  } deq_out_t;

endpackage

FILE: src/double_ended_queue.sv
// ============================================================================
// double_ended_queue: bounded deque of signed values in two cell chains
// Push/pop at either end; reports both end values, count, empty and status.
// ============================================================================
// Latency: the result is registered and valid the cycle after the input transfer.
// Throughput: one operation per cycle unless the input is stalled; a cell chain shifts all its cells at once.
// Input is stalled only while a result is pending and the output is stalled.
// Reset clears the fill count, the status and the output valid; stored values are
// undefined until written and are never read before that.
module double_ended_queue #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  deq_pkg::deq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output deq_pkg::deq_out_t out_data
);

  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned MINW = (DATA_WIDTH < deq_pkg::FIELD_WIDTH) ?
                                 DATA_WIDTH : deq_pkg::FIELD_WIDTH;

  // Two copies of the contents: the front chain keeps the front element in
  // cell 0, the back chain keeps the back element in cell 0 (reverse order).
  // So both ends are always read from a fixed cell. A push at an end shifts
  // that end's chain and writes the tail of the other one; a pop shifts one
  // chain and only shortens the other (count drop hides its tail cell).

  logic [CW-1:0]         count_r, count_nxt;
  logic                  out_valid_r, out_valid_nxt;
  deq_pkg::deq_status_t  status_r, status_nxt;

  deq_pkg::deq_cell_ctrl_t front_ctrl, back_ctrl;
  logic [DATA_WIDTH-1:0]   wr_data;
  logic [DATA_WIDTH-1:0]   front_head, back_head;
  deq_pkg::deq_func_t      func;

  logic in_xfer, out_xfer, is_full, is_empty;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  // hold input while an untaken result waits; state drives the payload
  assign in_stall = out_valid_r && out_stall;

  assign is_full  = (count_r == CW'(DEPTH));
  assign is_empty = (count_r == '0);
  assign func     = deq_pkg::deq_func_t'(in_data.func);
  assign wr_data  = DATA_WIDTH'(in_data.data_in[MINW-1:0]);

  always_comb begin
    count_nxt           = count_r;
    status_nxt          = status_r;
    out_valid_nxt       = out_valid_r;
    front_ctrl.op       = deq_pkg::CELL_HOLD;
    back_ctrl.op        = deq_pkg::CELL_HOLD;
    front_ctrl.tail_pos = deq_pkg::POS_WIDTH'(count_r);
    back_ctrl.tail_pos  = deq_pkg::POS_WIDTH'(count_r);

    if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end

    if (in_xfer) begin
      out_valid_nxt = 1'b1;
      status_nxt    = deq_pkg::STAT_OK;
      case (func)
        deq_pkg::FUNC_PUSH_FRONT: begin
          if (is_full) begin
            status_nxt = deq_pkg::STAT_FULL_PUSH;
          end else begin
            front_ctrl.op = deq_pkg::CELL_SHIFT_IN;
            back_ctrl.op  = deq_pkg::CELL_TAIL_WRITE;
            count_nxt     = count_r + 1'b1;
          end
        end
        deq_pkg::FUNC_PUSH_BACK: begin
          if (is_full) begin
            status_nxt = deq_pkg::STAT_FULL_PUSH;
          end else begin
            front_ctrl.op = deq_pkg::CELL_TAIL_WRITE;
            back_ctrl.op  = deq_pkg::CELL_SHIFT_IN;
            count_nxt     = count_r + 1'b1;
          end
        end
        deq_pkg::FUNC_POP_FRONT: begin
          if (is_empty) begin
            status_nxt = deq_pkg::STAT_EMPTY_POP;
          end else begin
            front_ctrl.op = deq_pkg::CELL_SHIFT_OUT;
            count_nxt     = count_r - 1'b1;
          end
        end
        deq_pkg::FUNC_POP_BACK: begin
          if (is_empty) begin
            status_nxt = deq_pkg::STAT_EMPTY_POP;
          end else begin
            back_ctrl.op = deq_pkg::CELL_SHIFT_OUT;
            count_nxt    = count_r - 1'b1;
          end
        end
        default: begin
          status_nxt = deq_pkg::STAT_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
      status_r    <= deq_pkg::STAT_OK;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
    end
  end

  deq_chain #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front_chain (
    .clk       (clk),
    .ctrl      (front_ctrl),
    .wr_data   (wr_data),
    .head_data (front_head)
  );

  deq_chain #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back_chain (
    .clk       (clk),
    .ctrl      (back_ctrl),
    .wr_data   (wr_data),
    .head_data (back_head)
  );

  // Result is read straight from state; state only moves on an input
  // transfer, which cannot happen while the result is stalled.
  always_comb begin
    out_data.front_value = is_empty ? '0 :
                           deq_pkg::FIELD_WIDTH'(front_head[MINW-1:0]);
    out_data.back_value  = is_empty ? '0 :
                           deq_pkg::FIELD_WIDTH'(back_head[MINW-1:0]);
    out_data.entry_count = deq_pkg::COUNT_WIDTH'(count_r);
    out_data.is_empty    = is_empty;
    out_data.status      = status_r;
  end

  assign out_valid = out_valid_r;

endmodule

FILE: src/deq_cell.sv
// ============================================================================
// deq_cell: one storage cell of a deque chain
// Holds one value; shifts from a neighbor or takes new data at the tail.
// ============================================================================
module deq_cell #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned IDX        = 0
) (
  input  logic                    clk,
  input  deq_pkg::deq_cell_ctrl_t ctrl,
  input  logic [DATA_WIDTH-1:0]   left_data,
  input  logic [DATA_WIDTH-1:0]   right_data,
  input  logic [DATA_WIDTH-1:0]   wr_data,
  output logic [DATA_WIDTH-1:0]   data_q
);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (ctrl.op)
      deq_pkg::CELL_SHIFT_IN:   data_nxt = left_data;
      deq_pkg::CELL_SHIFT_OUT:  data_nxt = right_data;
      deq_pkg::CELL_TAIL_WRITE: begin
        if (ctrl.tail_pos == deq_pkg::POS_WIDTH'(IDX)) begin
          data_nxt = wr_data;
        end
      end
      default:                  data_nxt = data_r;
    endcase
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

FILE: src/deq_chain.sv
// ============================================================================
// deq_chain: row of deque cells with the head at cell 0
// Cells pass values to their neighbors; only the head is read out.
// ============================================================================
module deq_chain #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                    clk,
  input  deq_pkg::deq_cell_ctrl_t ctrl,
  input  logic [DATA_WIDTH-1:0]   wr_data,
  output logic [DATA_WIDTH-1:0]   head_data
);

  logic [DATA_WIDTH-1:0] cell_q [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_d;
    logic [DATA_WIDTH-1:0] right_d;

    if (i == 0) begin : g_head
      assign left_d = wr_data;
    end else begin : g_mid
      assign left_d = cell_q[i-1];
    end

    // last cell refills from itself; its value is past the fill count then
    if (i == DEPTH - 1) begin : g_last
      assign right_d = cell_q[i];
    end else begin : g_inner
      assign right_d = cell_q[i+1];
    end

    deq_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX        (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .left_data  (left_d),
      .right_data (right_d),
      .wr_data    (wr_data),
      .data_q     (cell_q[i])
    );
  end

  assign head_data = cell_q[0];

endmodule

FILE: src/deq_checker.sv
// ============================================================================
// deq_checker: port-level checks for the double-ended queue
// Watches the channels only; attached to the top level by bind.
// ============================================================================
module deq_checker #(
  parameter int unsigned DEPTH = 16
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input deq_pkg::deq_out_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // every input transfer yields a result next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("no result after input transfer");

  // empty deque reports zero count and zero end values
  a_empty_vals: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_empty |->
      out_data.entry_count == '0 && out_data.front_value == '0 &&
      out_data.back_value == '0)
    else $error("empty deque with nonzero fields");

  // rejected pop only on empty, rejected push only on full
  a_status_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == deq_pkg::STAT_EMPTY_POP |-> out_data.is_empty)
    else $error("empty-pop status on nonempty deque");

  a_full_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == deq_pkg::STAT_FULL_PUSH |->
      out_data.entry_count == deq_pkg::COUNT_WIDTH'(DEPTH) && !out_data.is_empty)
    else $error("full-push status on non-full deque");

endmodule

bind double_ended_queue deq_checker #(
  .DEPTH (DEPTH)
) u_deq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

FILE: tb/double_ended_queue_test.sv
// ----------------------------------------------------------------------------
// double_ended_queue_test: self-checking bench for the bounded deque
// Sends insert/remove operations at both ends over a valid/stall channel and
// checks each reported snapshot (ends, count, empty, status) against a
// ring-buffer predictor. Both sides idle at random; the receiver also holds off
// for long stretches so that the block has to stall its input.
// ----------------------------------------------------------------------------
module double_ended_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DQ_DEPTH       = 16;
  localparam int FIRST_CHUNK    = 900;   // random ops before the mid-run drain
  localparam int RANDOM_OPS     = 1826;
  localparam int IDLE_PCT       = 6;
  localparam int HOLD_CYCLES    = 150;   // long receiver hold-off
  localparam int HOLD_EVERY     = 900;   // transfers between hold-offs
  localparam int CALM_LO        = 1300;  // no idling in [CALM_LO, CALM_HI)
  localparam int CALM_HI        = 1700;
  localparam int MAX_REPORTS    = 10;
  localparam int TAIL_CYCLES    = 10;    // result is registered, so plenty
  localparam int WATCHDOG_LIMIT = 1000;

  // --------------------------------------------------------------------------
  // Clock, reset, block ports
  // --------------------------------------------------------------------------
  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  deq_pkg::deq_in_t  in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  deq_pkg::deq_out_t out_data;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  double_ended_queue #(
    .DEPTH      (DQ_DEPTH),
    .DATA_WIDTH (deq_pkg::FIELD_WIDTH)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  deq_pkg::deq_in_t  op_pending[$];   // operations waiting for the driver
  deq_pkg::deq_out_t snap_q[$];       // predicted deque snapshots, oldest first

  int queued_total = 0;      // ops handed to the driver (initial block only)
  int op_acc_cnt   = 0;      // input transfers (NBA, driver)
  int out_cnt      = 0;      // output transfers (NBA, monitor)
  int fault_cnt    = 0;
  int stuck_cycles = 0;

  int hold_left    = 0;
  int next_hold_at = 300;
  int hold_cnt     = 0;
  int drain_cnt    = 0;

  // Predictor state: ring store, head index, index past the tail, fill.
  // Only occupied slots are ever read, so the store needs no reset.
  logic signed [deq_pkg::FIELD_WIDTH-1:0] dq_slot [DQ_DEPTH];
  int unsigned dq_head  = 0;
  int unsigned dq_tail  = 0;
  int unsigned dq_count = 0;

  // coverage tallies for the summary
  int ins_cnt = 0, rem_cnt = 0, full_cnt = 0, empty_cnt = 0, peak_fill = 0;

  // --------------------------------------------------------------------------
  // Predictor: apply one operation, queue the snapshot the block must report
  // --------------------------------------------------------------------------
  task automatic apply_deque_op(input deq_pkg::deq_in_t op);
    deq_pkg::deq_out_t  snap;
    deq_pkg::deq_func_t f;
    f = deq_pkg::deq_func_t'(op.func);
    snap = '0;
    snap.status = deq_pkg::STAT_OK;
    if (f == deq_pkg::FUNC_PUSH_FRONT || f == deq_pkg::FUNC_PUSH_BACK) begin
      if (dq_count == DQ_DEPTH) begin
        // full: value dropped, nothing moves
        snap.status = deq_pkg::STAT_FULL_PUSH;
        full_cnt++;
      end else if (f == deq_pkg::FUNC_PUSH_FRONT) begin
        dq_head = (dq_head + DQ_DEPTH - 1) % DQ_DEPTH;
        dq_slot[dq_head] = op.data_in;
        dq_count++;
        ins_cnt++;
      end else begin
        dq_slot[dq_tail] = op.data_in;
        dq_tail = (dq_tail + 1) % DQ_DEPTH;
        dq_count++;
        ins_cnt++;
      end
    end else begin
      if (dq_count == 0) begin
        // empty: flagged, nothing moves
        snap.status = deq_pkg::STAT_EMPTY_POP;
        empty_cnt++;
      end else if (f == deq_pkg::FUNC_POP_FRONT) begin
        dq_head = (dq_head + 1) % DQ_DEPTH;
        dq_count--;
        rem_cnt++;
      end else begin
        dq_tail = (dq_tail + DQ_DEPTH - 1) % DQ_DEPTH;
        dq_count--;
        rem_cnt++;
      end
    end
    // ends read as zero once the deque is empty
    if (dq_count != 0) begin
      snap.front_value = dq_slot[dq_head];
      snap.back_value  = dq_slot[(dq_tail + DQ_DEPTH - 1) % DQ_DEPTH];
    end
    snap.entry_count = deq_pkg::COUNT_WIDTH'(dq_count);
    snap.is_empty    = (dq_count == 0);
    if (int'(dq_count) > peak_fill) peak_fill = int'(dq_count);
    snap_q.push_back(snap);
  endtask

  task automatic note_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    fault_cnt++;
    if (fault_cnt <= MAX_REPORTS)
      $display("MISMATCH result %0d %s: expected %h, got %h", out_cnt, field, want, got);
  endtask

  // --------------------------------------------------------------------------
  // Driver: one transfer per accepted edge; payload held while stalled.
  // Idles ~6% of the time outside the calm window.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : driver_blk
    bit skip;
    skip = (op_acc_cnt < CALM_LO || op_acc_cnt >= CALM_HI) &&
           ($urandom_range(0, 99) < IDLE_PCT);
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_deque_op(in_data);
        op_acc_cnt <= op_acc_cnt + 1;
      end
      // free to present something new only when nothing is held
      if (!in_valid || !in_stall) begin
        if (op_pending.size() != 0 && !skip) begin
          in_data  <= op_pending.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver stall: random idling, plus a long hold-off after 300 results and then
  // every HOLD_EVERY results, so the single result register backs up into in_stall.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (out_cnt >= next_hold_at) begin
      hold_left    <= HOLD_CYCLES - 1;
      next_hold_at <= next_hold_at + HOLD_EVERY;
      hold_cnt     <= hold_cnt + 1;
      out_stall    <= 1'b1;
    end else begin
      out_stall <= (out_cnt < CALM_LO || out_cnt >= CALM_HI) &&
                   ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every result transfer is checked against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor_blk
    deq_pkg::deq_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      out_cnt <= out_cnt + 1;
      if (snap_q.size() == 0) begin
        fault_cnt++;
        if (fault_cnt <= MAX_REPORTS)
          $display("UNEXPECTED result %0d: %p", out_cnt, out_data);
      end else begin
        want = snap_q.pop_front();
        if (out_data.front_value !== want.front_value)
          note_mismatch("front_value", want.front_value, out_data.front_value);
        if (out_data.back_value !== want.back_value)
          note_mismatch("back_value", want.back_value, out_data.back_value);
        if (out_data.entry_count !== want.entry_count)
          note_mismatch("entry_count", 32'(want.entry_count),
                        32'(out_data.entry_count));
        if (out_data.is_empty !== want.is_empty)
          note_mismatch("is_empty", 32'(want.is_empty), 32'(out_data.is_empty));
        if (out_data.status !== want.status)
          note_mismatch("status", 32'(want.status), 32'(out_data.status));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long without any transfer on either side ends the run
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               stuck_cycles, snap_q.size());
      $display("DONE: errors detected");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic queue_op(input deq_pkg::deq_func_t f, input logic [31:0] d);
    deq_pkg::deq_in_t op;
    op.func    = f;
    op.data_in = d;
    op_pending.push_back(op);
    queued_total++;
  endtask

  // Sender pause: hold back until every queued op is in and answered.
  task automatic wait_drained();
    while (op_acc_cnt != queued_total || snap_q.size() != 0) @(posedge clk);
    drain_cnt++;
  endtask

  // Random ops in bursts biased toward filling, draining or wandering, so the
  // deque keeps hitting full and empty and both pointers wrap often.
  task automatic queue_random_ops(input int n);
    int burst_left;
    int push_pct;
    int sel;
    deq_pkg::deq_func_t f;
    logic [31:0] d;
    burst_left = 0;
    push_pct   = 50;
    for (int i = 0; i < n; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(20, 60);
        case ($urandom_range(0, 2))
          0:       push_pct = 80;
          1:       push_pct = 20;
          default: push_pct = 50;
        endcase
      end
      burst_left--;
      if ($urandom_range(0, 99) < push_pct)
        f = $urandom_range(0, 1) ? deq_pkg::FUNC_PUSH_BACK : deq_pkg::FUNC_PUSH_FRONT;
      else
        f = $urandom_range(0, 1) ? deq_pkg::FUNC_POP_BACK : deq_pkg::FUNC_POP_FRONT;
      sel = $urandom_range(0, 9);
      case (sel)
        0:       d = 32'h7FFF_FFFF;
        1:       d = 32'h8000_0000;
        2:       d = 32'h0000_0000;
        3:       d = 32'hFFFF_FFFF;
        default: d = $urandom();
      endcase
      queue_op(f, d);
    end
  endtask

  initial begin
    // Directed: removals from empty at both ends, single element in and out
    // at each end, then a fill to full alternating ends (front pushes wrap
    // the head below zero) and one insertion at each end while full.
    queue_op(deq_pkg::FUNC_POP_FRONT,  32'h1234_5678);
    queue_op(deq_pkg::FUNC_POP_BACK,   32'hFFFF_FFFF);
    queue_op(deq_pkg::FUNC_PUSH_FRONT, 32'h7FFF_FFFF);
    queue_op(deq_pkg::FUNC_POP_FRONT,  32'h0000_0000);
    queue_op(deq_pkg::FUNC_PUSH_BACK,  32'h8000_0000);
    queue_op(deq_pkg::FUNC_POP_BACK,   32'h0000_0000);
    for (int i = 0; i < DQ_DEPTH; i++) begin
      case (i % 4)
        0:       queue_op(deq_pkg::FUNC_PUSH_FRONT, 32'h7FFF_FFFF);
        1:       queue_op(deq_pkg::FUNC_PUSH_BACK,  32'h8000_0000);
        2:       queue_op(deq_pkg::FUNC_PUSH_FRONT, 32'hFFFF_FFFF);
        default: queue_op(deq_pkg::FUNC_PUSH_BACK,  32'(i));
      endcase
    end
    queue_op(deq_pkg::FUNC_PUSH_FRONT, 32'hAAAA_AAAA);
    queue_op(deq_pkg::FUNC_PUSH_BACK,  32'h5555_5555);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    wait_drained();
    queue_random_ops(FIRST_CHUNK);
    wait_drained();
    queue_random_ops(RANDOM_OPS - FIRST_CHUNK);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (snap_q.size() != 0) begin
      fault_cnt++;
      $display("MISSING: %0d predicted results never arrived", snap_q.size());
    end

    $display("Covered %0d ops: %0d inserts, %0d removals, %0d full rejects,",
             op_acc_cnt, ins_cnt, rem_cnt, full_cnt);
    $display("  %0d empty rejects, peak fill %0d, receiver hold-offs %0d,",
             empty_cnt, peak_fill, hold_cnt);
    $display("  sender drains %0d, results checked %0d", drain_cnt, out_cnt);
    if (fault_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/deq_pkg.sv
src/deq_cell.sv
src/deq_chain.sv
src/double_ended_queue.sv
src/deq_checker.sv
tb/double_ended_queue_test.sv
